/* rtl/core/bankers_safety_allocator_assert.svh */
// Assertion macros used by the allocator's checker file.
`ifndef BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH
`define BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bsa_pkg.sv */
// Shared types, field widths and codes of the banker's allocator.
package bsa_pkg;

    // Field widths of the item channels and the configuration port
    localparam int NUM_KINDS  = 3;
    localparam int CMD_W      = 2;
    localparam int PROC_W     = 3;
    localparam int AMT_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int AVAIL_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Command codes; the fourth code is reserved and refused
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECLARE = 2'd2;

    // Capacity values loaded at reset, one per resource kind
    localparam logic [CFG_DATA_W-1:0] CAP_RESET [NUM_KINDS] = '{4'd1, 4'd1, 4'd2};

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_EXCEED  = 3'd1,
        ST_NOAVAIL = 3'd2,
        ST_UNSAFE  = 3'd3,
        ST_REFUSED = 3'd4
    } alloc_status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic step;
        logic undo;
        logic publish;
    } dp_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic grant;
        logic srch_end;
        logic srch_safe;
    } dp_stat_t;

endpackage

/* rtl/core/bsa_if.sv */
// Command and response channel interfaces of the banker's allocator.
interface alloc_req_if;
    import bsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [PROC_W-1:0]   proc;
    logic [AMT_W-1:0]    amount_0;
    logic [AMT_W-1:0]    amount_1;
    logic [AMT_W-1:0]    amount_2;

    modport source (output valid, output cmd, output proc,
                    output amount_0, output amount_1, output amount_2, input ready);
    modport sink   (input valid, input cmd, input proc,
                    input amount_0, input amount_1, input amount_2, output ready);
endinterface

interface alloc_rsp_if;
    import bsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AVAIL_W-1:0]  avail_0;
    logic [AVAIL_W-1:0]  avail_1;
    logic [AVAIL_W-1:0]  avail_2;

    modport source (output valid, output status, output avail_0, output avail_1,
                    output avail_2, input ready);
    modport sink   (input valid, input status, input avail_0, input avail_1,
                    input avail_2, output ready);
endinterface

/* rtl/core/bsa_datapath.sv */
// Datapath of the banker's allocator: claim tables, pools and safety scan.
module bsa_datapath #(
    parameter int NUM_PROCS   = 8,
    parameter int COUNT_WIDTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsa_pkg::dp_ctrl_t             ctrl,
    output bsa_pkg::dp_stat_t             stat,
    input  logic                          cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bsa_pkg::CMD_W-1:0]      in_cmd,
    input  logic [bsa_pkg::PROC_W-1:0]     in_proc,
    input  logic [bsa_pkg::AMT_W-1:0]      in_amount_0,
    input  logic [bsa_pkg::AMT_W-1:0]      in_amount_1,
    input  logic [bsa_pkg::AMT_W-1:0]      in_amount_2,
    output bsa_pkg::alloc_status_t         out_status,
    output logic [bsa_pkg::AVAIL_W-1:0]    out_avail_0,
    output logic [bsa_pkg::AVAIL_W-1:0]    out_avail_1,
    output logic [bsa_pkg::AVAIL_W-1:0]    out_avail_2
);
    import bsa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_PROCS);
    localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_PROCS + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Per-process tables and per-kind pools
    logic [COUNT_WIDTH-1:0] max_reg   [NUM_PROCS][NUM_KINDS];
    logic [COUNT_WIDTH-1:0] held_reg  [NUM_PROCS][NUM_KINDS];
    logic [COUNT_WIDTH-1:0] avail_reg [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] avail_next[NUM_KINDS];
    logic [WORK_W-1:0]      total_reg [NUM_KINDS];
    logic [WORK_W-1:0]      total_next[NUM_KINDS];
    logic [COUNT_WIDTH-1:0] cap_new   [NUM_KINDS];
    logic                   cap_wr    [NUM_KINDS];

    // Captured item
    logic [CMD_W-1:0]       cmd_reg;
    logic [PROC_W-1:0]      proc_reg;
    logic [COUNT_WIDTH-1:0] amt_reg   [NUM_KINDS];
    logic [AMT_W-1:0]       in_amt    [NUM_KINDS];
    alloc_status_t          status_reg;

    // Safety scan state
    logic [IDX_W-1:0]       idx_reg;
    logic [NUM_PROCS-1:0]   done_reg;
    logic                   progress_reg;
    logic [WORK_W-1:0]      work_reg  [NUM_KINDS];

    // Response register
    alloc_status_t          out_status_reg;
    logic [AVAIL_W-1:0]     out_avail_reg [NUM_KINDS];

    // Entry read and derived values
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       pidx;
    logic [COUNT_WIDTH-1:0] rd_max    [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] rd_held   [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] need      [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] rel       [NUM_KINDS];
    logic [COUNT_WIDTH:0]   rel_sum   [NUM_KINDS];
    logic                   proc_ok;
    logic                   exceed;
    logic                   noavail;
    logic                   holds;
    logic                   grant;
    logic                   rel_go;
    logic                   decl_go;
    alloc_status_t          chk_status;
    logic                   fits;
    logic                   last;
    logic [NUM_PROCS-1:0]   done_step;
    logic                   all_done;

    assign in_amt[0] = in_amount_0;
    assign in_amt[1] = in_amount_1;
    assign in_amt[2] = in_amount_2;

    // Address the table with the scan index while scanning, else the item's process
    assign pidx    = IDX_W'(proc_reg);
    assign rd_idx  = ctrl.step ? idx_reg : pidx;
    assign proc_ok = int'(proc_reg) < NUM_PROCS;

    // Read one entry; derive need and clamped release per kind
    always_comb
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            rd_max[k]  = max_reg[rd_idx][k];
            rd_held[k] = held_reg[rd_idx][k];
            need[k]    = (rd_held[k] >= rd_max[k]) ? '0 : rd_max[k] - rd_held[k];
            rel[k]     = (amt_reg[k] > rd_held[k]) ? rd_held[k] : amt_reg[k];
            rel_sum[k] = {1'b0, avail_reg[k]} + {1'b0, rel[k]};
        end
    end

    // Decide the command's outcome
    always_comb
    begin
        exceed  = 1'b0;
        noavail = 1'b0;
        holds   = 1'b0;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            exceed  = exceed  | (amt_reg[k] > need[k]);
            noavail = noavail | (amt_reg[k] > avail_reg[k]);
            holds   = holds   | (rd_held[k] != '0);
        end
        grant   = 1'b0;
        rel_go  = 1'b0;
        decl_go = 1'b0;
        priority if (!proc_ok)
        begin
            chk_status = ST_REFUSED;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_REQUEST:
                begin
                    priority if (exceed)  chk_status = ST_EXCEED;
                    else if (noavail)     chk_status = ST_NOAVAIL;
                    else
                    begin
                        chk_status = ST_DONE;
                        grant      = 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    chk_status = ST_DONE;
                    rel_go     = 1'b1;
                end
                CMD_DECLARE:
                begin
                    chk_status = holds ? ST_REFUSED : ST_DONE;
                    decl_go    = !holds;
                end
                default: chk_status = ST_REFUSED;
            endcase
        end
    end

    // Evaluate one scan step on the addressed entry
    always_comb
    begin
        fits = !done_reg[idx_reg];
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            fits = fits & (WORK_W'(need[k]) <= work_reg[k]);
        end
        done_step          = done_reg;
        done_step[idx_reg] = done_reg[idx_reg] | fits;
        last               = (idx_reg == IDX_W'(NUM_PROCS - 1));
        all_done           = &done_step;
    end

    assign stat.grant     = grant;
    assign stat.srch_end  = all_done || (last && !(progress_reg || fits));
    assign stat.srch_safe = all_done;

    // Next pool values: command updates, capacity reload on a write
    always_comb
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            cap_wr[k]     = cfg_wr_en && (cfg_index == CFG_IDX_W'(k));
            cap_new[k]    = COUNT_WIDTH'(cfg_data);
            avail_next[k] = avail_reg[k];
            total_next[k] = total_reg[k];
            priority if (ctrl.check && grant)
            begin
                avail_next[k] = avail_reg[k] - amt_reg[k];
                total_next[k] = total_reg[k] + WORK_W'(amt_reg[k]);
            end
            else if (ctrl.check && rel_go)
            begin
                avail_next[k] = rel_sum[k][COUNT_WIDTH] ? COUNT_MAX
                                                        : rel_sum[k][COUNT_WIDTH-1:0];
                total_next[k] = total_reg[k] - WORK_W'(rel[k]);
            end
            else if (ctrl.undo)
            begin
                avail_next[k] = avail_reg[k] + amt_reg[k];
                total_next[k] = total_reg[k] - WORK_W'(amt_reg[k]);
            end
            if (cap_wr[k])
            begin
                avail_next[k] = (total_reg[k] >= WORK_W'(cap_new[k])) ? '0
                              : COUNT_WIDTH'(WORK_W'(cap_new[k]) - total_reg[k]);
            end
        end
    end

    // Hold pools
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                avail_reg[k] <= COUNT_WIDTH'(CAP_RESET[k]);
                total_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                avail_reg[k] <= avail_next[k];
                total_reg[k] <= total_next[k];
            end
        end
    end

    // Update the claim and holding tables at the item's process
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    max_reg[p][k]  <= '0;
                    held_reg[p][k] <= '0;
                end
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                priority if (ctrl.check && grant)
                    held_reg[pidx][k] <= rd_held[k] + amt_reg[k];
                else if (ctrl.check && rel_go)
                    held_reg[pidx][k] <= rd_held[k] - rel[k];
                else if (ctrl.check && decl_go)
                    max_reg[pidx][k]  <= amt_reg[k];
                else if (ctrl.undo)
                    held_reg[pidx][k] <= rd_held[k] - amt_reg[k];
            end
        end
    end

    // Sequence the safety scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            done_reg     <= '0;
            progress_reg <= 1'b0;
        end
        else if (ctrl.check)
        begin
            idx_reg      <= '0;
            done_reg     <= '0;
            progress_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            done_reg     <= done_step;
            idx_reg      <= last ? '0 : idx_reg + 1'b1;
            progress_reg <= last ? 1'b0 : (progress_reg | fits);
        end
    end

    // Capture the item, seed and grow the work pool, load the response
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= in_cmd;
            proc_reg <= in_proc;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                amt_reg[k] <= COUNT_WIDTH'(in_amt[k]);
            end
        end
        if (ctrl.check)
        begin
            status_reg <= chk_status;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                work_reg[k] <= WORK_W'(avail_reg[k] - amt_reg[k]);
            end
        end
        else if (ctrl.step && fits)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                work_reg[k] <= work_reg[k] + WORK_W'(rd_held[k]);
            end
        end
        if (ctrl.undo)
        begin
            status_reg <= ST_UNSAFE;
        end
        if (ctrl.publish)
        begin
            out_status_reg <= status_reg;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                out_avail_reg[k] <= AVAIL_W'(avail_reg[k]);
            end
        end
    end

    assign out_status  = out_status_reg;
    assign out_avail_0 = out_avail_reg[0];
    assign out_avail_1 = out_avail_reg[1];
    assign out_avail_2 = out_avail_reg[2];

endmodule

/* rtl/core/bsa_controller.sv */
// Controller of the banker's allocator: item sequencing and response valid.
module bsa_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output bsa_pkg::dp_ctrl_t ctrl,
    input  bsa_pkg::dp_stat_t stat
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_UNDO,
        S_PUB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Issue datapath commands and pick the next state
    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.load = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctrl.check = 1'b1;
                state_next = stat.grant ? S_SEARCH : S_PUB;
            end
            S_SEARCH:
            begin
                ctrl.step = 1'b1;
                if (stat.srch_end)
                    state_next = stat.srch_safe ? S_PUB : S_UNDO;
            end
            S_UNDO:
            begin
                ctrl.undo  = 1'b1;
                state_next = S_PUB;
            end
            S_PUB:
            begin
                if (out_free)
                begin
                    ctrl.publish = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        priority if (ctrl.publish) out_valid_next = 1'b1;
        else if (out_ready)        out_valid_next = 1'b0;
        else                       out_valid_next = out_valid_reg;
    end

    // Hold state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/bankers_safety_allocator.sv */
// Top level of the banker's deadlock-avoidance allocator.
// Banker's allocator for three resource kinds over NUM_PROCS processes. Each
// command item gives one response item: request, release or declare-maximum,
// answered with a status and the units available afterwards. The block takes
// one item at a time. Release, declare and refused requests pass through a
// check state and then a publish state before their response is loaded. A
// request that passes the need and availability checks runs the safety scan,
// which reads one process entry per cycle from the claim and holding tables
// through a single read port; a pass covers all NUM_PROCS entries and up to
// NUM_PROCS passes run. An unsafe request goes through an undo state that
// rolls back its grant. The response sits in an output register;
// the publish step waits while that register still holds an unaccepted item,
// and the next item is taken the cycle after the response is loaded. A capacity
// write reloads that kind's availability as capacity minus the units held,
// floored at zero, in the same cycle; write capacities only while idle.
module bankers_safety_allocator #(
    parameter int NUM_PROCS   = 8,
    parameter int COUNT_WIDTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data,
    alloc_req_if.sink                      req,
    alloc_rsp_if.source                    rsp
);
    import bsa_pkg::*;

    dp_ctrl_t      ctrl;
    dp_stat_t      stat;
    alloc_status_t dp_status;

    // Sequence items
    bsa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // Tables, pools and safety scan
    bsa_datapath #(
        .NUM_PROCS   (NUM_PROCS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_cmd      (req.cmd),
        .in_proc     (req.proc),
        .in_amount_0 (req.amount_0),
        .in_amount_1 (req.amount_1),
        .in_amount_2 (req.amount_2),
        .out_status  (dp_status),
        .out_avail_0 (rsp.avail_0),
        .out_avail_1 (rsp.avail_1),
        .out_avail_2 (rsp.avail_2)
    );

    assign rsp.status = dp_status;

endmodule

/* rtl/core/bsa_checker.sv */
// Port-level checker of the banker's allocator and its bind.
`include "bankers_safety_allocator_assert.svh"

module bsa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [bsa_pkg::STATUS_W-1:0] rsp_status,
    input logic [bsa_pkg::AVAIL_W-1:0]  rsp_avail_0,
    input logic [bsa_pkg::AVAIL_W-1:0]  rsp_avail_1,
    input logic [bsa_pkg::AVAIL_W-1:0]  rsp_avail_2
);
    import bsa_pkg::*;

    // A stalled response keeps its item
    `BSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_avail_0) && $stable(rsp_avail_1) && $stable(rsp_avail_2), "stalled response changed")

    // Only defined status codes leave the block
    `BSA_ASSERT_SAME(a_status_code, rsp_valid, rsp_status <= STATUS_W'(ST_REFUSED), "undefined status code")

    // One item at a time: busy right after an item is taken
    `BSA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted item while busy")

    // A response needs at least the check state after acceptance
    `BSA_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "response without check cycle")

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_avail_0 (rsp.avail_0),
    .rsp_avail_1 (rsp.avail_1),
    .rsp_avail_2 (rsp.avail_2)
);

/* tb/bankers_safety_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the banker's allocator with its own allocation predictor.
module bankers_safety_allocator_test;
    import bsa_pkg::*;

    localparam int NPROC = 8;
    localparam int UNIT_MAX = 15;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES = 6;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam logic [AVAIL_W-1:0] PHASE_CAPS [4][NUM_KINDS] = '{
        '{4'd15, 4'd15, 4'd15},
        '{4'd0,  4'd0,  4'd0},
        '{4'd3,  4'd5,  4'd2},
        '{4'd15, 4'd0,  4'd7}
    };

    typedef struct packed {
        logic [CMD_W-1:0]                  cmd;
        logic [PROC_W-1:0]                 proc;
        logic [NUM_KINDS-1:0][AMT_W-1:0]   amount;
    } alloc_cmd_t;

    typedef struct packed {
        alloc_status_t                     status;
        logic [NUM_KINDS-1:0][AVAIL_W-1:0] avail;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alloc_req_if req_ch ();
    alloc_rsp_if rsp_ch ();

    // Predictor state: capacities, claim and holding tables, free pool
    logic [AVAIL_W-1:0] cap_units [NUM_KINDS];
    logic [AVAIL_W-1:0] claim_units [NPROC][NUM_KINDS];
    logic [AVAIL_W-1:0] holding [NPROC][NUM_KINDS];
    logic [AVAIL_W-1:0] free_units [NUM_KINDS];

    alloc_cmd_t pending_cmds [$];
    alloc_rsp_t awaited_rsp [$];
    alloc_cmd_t on_wire;
    alloc_rsp_t want;

    int mismatches = 0;
    int cycles = 0;
    int burst_left;
    int gap_left;
    int gap_max = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0] stall_pos;

    bankers_safety_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Units a process may still ask for; zero if it somehow holds more than its claim
    function automatic int remaining_need(int p, int k);
        return (holding[p][k] >= claim_units[p][k]) ? 0 : claim_units[p][k] - holding[p][k];
    endfunction

    // Safety search: keep finishing processes whose need fits the working pool
    function automatic bit pool_is_safe();
        int work [NUM_KINDS];
        bit finished [NPROC];
        bit progress;
        bit fits;
        for (int k = 0; k < NUM_KINDS; k++)
            work[k] = free_units[k];
        for (int p = 0; p < NPROC; p++)
            finished[p] = 1'b0;
        progress = 1'b1;
        while (progress)
        begin
            progress = 1'b0;
            for (int p = 0; p < NPROC; p++)
            begin
                if (!finished[p])
                begin
                    fits = 1'b1;
                    for (int k = 0; k < NUM_KINDS; k++)
                        if (remaining_need(p, k) > work[k])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (int k = 0; k < NUM_KINDS; k++)
                            work[k] += holding[p][k];
                        finished[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        for (int p = 0; p < NPROC; p++)
            if (!finished[p])
                return 1'b0;
        return 1'b1;
    endfunction

    // Free pool of one kind after a capacity change, floored at zero
    function automatic void reload_free(int k);
        int total;
        total = 0;
        for (int p = 0; p < NPROC; p++)
            total += holding[p][k];
        free_units[k] = (total >= cap_units[k]) ? '0 : AVAIL_W'(cap_units[k] - total);
    endfunction

    // Apply one command item to the predicted state and return the response
    function automatic alloc_rsp_t allocate_units(alloc_cmd_t c);
        alloc_rsp_t r;
        alloc_status_t st;
        int p;
        int give;
        bit holds;
        st = ST_DONE;
        p = c.proc;
        if (c.cmd == CMD_REQUEST)
        begin
            // Need checks first, then availability, then the tentative grant
            for (int k = 0; k < NUM_KINDS; k++)
                if (c.amount[k] > remaining_need(p, k))
                    st = ST_EXCEED;
            if (st == ST_DONE)
                for (int k = 0; k < NUM_KINDS; k++)
                    if (c.amount[k] > free_units[k])
                        st = ST_NOAVAIL;
            if (st == ST_DONE)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    free_units[k] -= c.amount[k];
                    holding[p][k] += c.amount[k];
                end
                if (!pool_is_safe())
                begin
                    for (int k = 0; k < NUM_KINDS; k++)
                    begin
                        free_units[k] += c.amount[k];
                        holding[p][k] -= c.amount[k];
                    end
                    st = ST_UNSAFE;
                end
            end
        end
        else if (c.cmd == CMD_RELEASE)
        begin
            // Clamp to what is held; saturate the pool
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                give = (c.amount[k] > holding[p][k]) ? holding[p][k] : c.amount[k];
                holding[p][k] -= give;
                free_units[k] = (free_units[k] + give > UNIT_MAX) ? AVAIL_W'(UNIT_MAX)
                                                                   : AVAIL_W'(free_units[k] + give);
            end
        end
        else if (c.cmd == CMD_DECLARE)
        begin
            holds = 1'b0;
            for (int k = 0; k < NUM_KINDS; k++)
                if (holding[p][k] != 0)
                    holds = 1'b1;
            if (holds)
                st = ST_REFUSED;
            else
                for (int k = 0; k < NUM_KINDS; k++)
                    claim_units[p][k] = c.amount[k];
        end
        else
        begin
            st = ST_REFUSED;
        end
        r.status = st;
        for (int k = 0; k < NUM_KINDS; k++)
            r.avail[k] = free_units[k];
        return r;
    endfunction

    // Mostly small amounts, now and then anything up to the field's top
    function automatic logic [AMT_W-1:0] pick_amount(int top);
        if ($urandom_range(0, 9) == 0)
            return AMT_W'($urandom_range(0, UNIT_MAX));
        return AMT_W'($urandom_range(0, top));
    endfunction

    task automatic add_item(logic [CMD_W-1:0] cmd, int proc, int a0, int a1, int a2);
        alloc_cmd_t c;
        c.cmd = cmd;
        c.proc = PROC_W'(proc);
        c.amount[0] = AMT_W'(a0);
        c.amount[1] = AMT_W'(a1);
        c.amount[2] = AMT_W'(a2);
        pending_cmds.push_back(c);
    endtask

    // Hold until every queued item is sent and every response is back
    task automatic drain_items();
        while (pending_cmds.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(int k, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(k);
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_units[k] = value;
        reload_free(k);
    endtask

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Command driver: bursts of items with random gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.cmd      <= '0;
            req_ch.proc     <= '0;
            req_ch.amount_0 <= '0;
            req_ch.amount_1 <= '0;
            req_ch.amount_2 <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                awaited_rsp.push_back(allocate_units(on_wire));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    on_wire = pending_cmds.pop_front();
                    req_ch.cmd      <= on_wire.cmd;
                    req_ch.proc     <= on_wire.proc;
                    req_ch.amount_0 <= on_wire.amount[0];
                    req_ch.amount_1 <= on_wire.amount[1];
                    req_ch.amount_2 <= on_wire.amount[2];
                    req_ch.valid    <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0 && gap_max > 0)
                        gap_left = $urandom_range(1, gap_max);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: stall on the phase pattern, check against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_pos <= '0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("response item with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.avail_0 !== want.avail[0])
                    begin
                        $error("avail_0: expected %0d, got %0d", want.avail[0], rsp_ch.avail_0);
                        mismatches++;
                    end
                    if (rsp_ch.avail_1 !== want.avail[1])
                    begin
                        $error("avail_1: expected %0d, got %0d", want.avail[1], rsp_ch.avail_1);
                        mismatches++;
                    end
                    if (rsp_ch.avail_2 !== want.avail[2])
                    begin
                        $error("avail_2: expected %0d, got %0d", want.avail[2], rsp_ch.avail_2);
                        mismatches++;
                    end
                end
            end
            rsp_ch.ready <= stall_pat[stall_pos];
            stall_pos <= stall_pos + 4'd1;
        end
    end

    // Stimulus and phase sequencing
    initial
    begin
        alloc_cmd_t c;
        int pick;
        logic [CFG_DATA_W-1:0] cap;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.proc = '0;
        req_ch.amount_0 = '0;
        req_ch.amount_1 = '0;
        req_ch.amount_2 = '0;
        rsp_ch.ready = 1'b0;

        for (int k = 0; k < NUM_KINDS; k++)
        begin
            cap_units[k] = CAP_RESET[k];
            free_units[k] = CAP_RESET[k];
            for (int p = 0; p < NPROC; p++)
            begin
                claim_units[p][k] = '0;
                holding[p][k] = '0;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items on the reset capacities
        add_item(CMD_RESERVED, 0, 15, 15, 15);
        add_item(CMD_REQUEST, 0, 0, 0, 0);      // idle process, zero request
        add_item(CMD_REQUEST, 0, 1, 0, 0);      // over its need
        add_item(CMD_DECLARE, 0, 1, 1, 2);
        add_item(CMD_DECLARE, 1, 1, 1, 2);
        add_item(CMD_REQUEST, 0, 1, 0, 1);      // safe grant
        add_item(CMD_REQUEST, 1, 1, 0, 0);      // pool too small
        add_item(CMD_REQUEST, 1, 2, 5, 9);      // need check wins over availability
        add_item(CMD_REQUEST, 1, 0, 1, 1);      // grant would deadlock
        add_item(CMD_DECLARE, 0, 2, 2, 2);      // refused while holding
        add_item(CMD_RELEASE, 0, 15, 15, 15);   // clamped to held
        add_item(CMD_DECLARE, 7, 15, 15, 15);
        add_item(CMD_REQUEST, 7, 15, 15, 15);
        add_item(CMD_REQUEST, 7, 1, 1, 2);
        add_item(CMD_DECLARE, 7, 1, 1, 1);
        add_item(CMD_REQUEST, 7, 1, 1, 1);
        add_item(CMD_RELEASE, 7, 0, 0, 0);
        add_item(CMD_RELEASE, 7, 15, 0, 1);
        add_item(CMD_RELEASE, 3, 15, 15, 15);   // release from a process holding nothing
        add_item(CMD_DECLARE, 7, 0, 0, 0);
        add_item(CMD_RELEASE, 7, 15, 15, 15);
        add_item(CMD_DECLARE, 7, 0, 0, 0);
        add_item(CMD_RESERVED, 5, 0, 0, 0);
        drain_items();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // New capacities while idle; held units carry over between phases
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                cap = (ph < 4) ? PHASE_CAPS[ph][k] : CFG_DATA_W'($urandom_range(0, UNIT_MAX));
                write_capacity(k, cap);
            end
            @(negedge clk);
            gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
            stall_pat = (ph % 2 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                c.proc = PROC_W'($urandom_range(0, NPROC - 1));
                if (pick < 40)
                begin
                    c.cmd = CMD_REQUEST;
                    for (int k = 0; k < NUM_KINDS; k++)
                        c.amount[k] = pick_amount(2);
                end
                else if (pick < 65)
                begin
                    c.cmd = CMD_RELEASE;
                    for (int k = 0; k < NUM_KINDS; k++)
                        c.amount[k] = $urandom_range(0, 1) ? AMT_W'(UNIT_MAX) : pick_amount(3);
                end
                else if (pick < 90)
                begin
                    c.cmd = CMD_DECLARE;
                    for (int k = 0; k < NUM_KINDS; k++)
                        c.amount[k] = pick_amount(5);
                end
                else if (pick < 95)
                begin
                    c.cmd = CMD_RESERVED;
                    for (int k = 0; k < NUM_KINDS; k++)
                        c.amount[k] = AMT_W'($urandom_range(0, UNIT_MAX));
                end
                else
                begin
                    c.cmd = CMD_W'($urandom_range(0, 3));
                    for (int k = 0; k < NUM_KINDS; k++)
                        c.amount[k] = AMT_W'($urandom_range(0, UNIT_MAX));
                end
                pending_cmds.push_back(c);
            end
            drain_items();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bsa_pkg.sv
rtl/core/bsa_if.sv
rtl/core/bsa_datapath.sv
rtl/core/bsa_controller.sv
rtl/core/bankers_safety_allocator.sv
rtl/core/bsa_checker.sv
tb/bankers_safety_allocator_test.sv
